### design/qte_pkg.sv
// Shared constants and the arctangent table for the quaternion to Euler angle block.
`default_nettype none
package qte_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int ANGLE_STAGES_DEF    = 16;
    localparam int ATAN_LEN            = 24;
    localparam int ZW                  = 27;
    localparam int ROLL_LIMIT          = 23040;
    localparam int PITCH_LIMIT         = 11520;
    localparam int DEG180              = 180 * 65536;
    localparam int QUEUE_DEPTH         = 4;

    // Angle of atan(2^-i) in degrees times 65536, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 27'sd2949120;
            1:       v = 27'sd1740967;
            2:       v = 27'sd919879;
            3:       v = 27'sd466945;
            4:       v = 27'sd234379;
            5:       v = 27'sd117304;
            6:       v = 27'sd58666;
            7:       v = 27'sd29335;
            8:       v = 27'sd14668;
            9:       v = 27'sd7334;
            10:      v = 27'sd3667;
            11:      v = 27'sd1833;
            12:      v = 27'sd917;
            13:      v = 27'sd458;
            14:      v = 27'sd229;
            15:      v = 27'sd115;
            16:      v = 27'sd57;
            17:      v = 27'sd29;
            18:      v = 27'sd14;
            19:      v = 27'sd7;
            20:      v = 27'sd4;
            21:      v = 27'sd2;
            22:      v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/qte_if.sv
// Valid/ready channel interfaces for quaternion input beats and angle output beats.
`default_nettype none
interface qte_quat_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] quat_w;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_deg;
    logic signed [14:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic               pitch_clamped;
    modport source (output valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, input ready);
    modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, output ready);
endinterface
`default_nettype wire

### design/qte_front.sv
// Front end: component products, vector sums, sine clamp and the sqrt operand.
`default_nettype none
module qte_front import qte_pkg::*; #(
    parameter int CW = COMPONENT_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    qte_quat_if.sink        i_quat,
    input  wire logic       i_full,
    output logic            o_push,
    output logic [4*(CW+4)+CW+2*CW-2:0] o_work
);
    localparam int PW = CW + 2;
    localparam int VW = CW + 4;
    localparam int NW = 2 * CW - 2;

    logic r_v1, r_v2, r_v3;
    logic en;

    logic signed [CW-1:0]   a_op [10];
    logic signed [CW-1:0]   b_op [10];
    logic signed [2*CW-1:0] prod [10];
    logic signed [PW-1:0]   r_p  [10];
    logic signed [PW-1:0]   n_p  [10];

    logic signed [VW-1:0] r_roll_y, r_roll_x, r_yaw_y, r_yaw_x;
    logic signed [VW-1:0] n_roll_y, n_roll_x, n_yaw_y, n_yaw_x;
    logic signed [VW-1:0] s_raw;
    logic signed [CW-1:0] r_s, n_s;
    logic                 r_cl, n_cl;

    logic signed [VW-1:0] r3_roll_y, r3_roll_x, r3_yaw_y, r3_yaw_x;
    logic signed [CW-1:0] r3_s;
    logic                 r3_cl;
    logic [NW-1:0]        r3_n, n_n;
    logic signed [2*CW-1:0] sq, diff;

    // Stall the whole front only when its last stage cannot enter the queue.
    assign en           = !(r_v3 && i_full);
    assign o_push       = r_v3 && !i_full;
    assign i_quat.ready = en;

    // Operand pairs: ww xx yy zz xy zw yz xw yw xz.
    assign a_op[0] = i_quat.quat_w; assign b_op[0] = i_quat.quat_w;
    assign a_op[1] = i_quat.quat_x; assign b_op[1] = i_quat.quat_x;
    assign a_op[2] = i_quat.quat_y; assign b_op[2] = i_quat.quat_y;
    assign a_op[3] = i_quat.quat_z; assign b_op[3] = i_quat.quat_z;
    assign a_op[4] = i_quat.quat_x; assign b_op[4] = i_quat.quat_y;
    assign a_op[5] = i_quat.quat_z; assign b_op[5] = i_quat.quat_w;
    assign a_op[6] = i_quat.quat_y; assign b_op[6] = i_quat.quat_z;
    assign a_op[7] = i_quat.quat_x; assign b_op[7] = i_quat.quat_w;
    assign a_op[8] = i_quat.quat_y; assign b_op[8] = i_quat.quat_w;
    assign a_op[9] = i_quat.quat_x; assign b_op[9] = i_quat.quat_z;

    // Exact products, floor shifted back to the component scale.
    always_comb begin
        for (int k = 0; k < 10; k++) begin
            prod[k] = a_op[k] * b_op[k];
            n_p[k]  = PW'(prod[k] >>> (CW - 2));
        end
    end

    // Vector sums and the clamped sine of pitch.
    always_comb begin
        n_yaw_y  = (VW'(r_p[4]) + VW'(r_p[5])) <<< 1;
        n_yaw_x  = VW'(r_p[1]) - VW'(r_p[2]) - VW'(r_p[3]) + VW'(r_p[0]);
        n_roll_y = (VW'(r_p[6]) + VW'(r_p[7])) <<< 1;
        n_roll_x = VW'(r_p[3]) + VW'(r_p[0]) - VW'(r_p[1]) - VW'(r_p[2]);
        s_raw    = (VW'(r_p[8]) - VW'(r_p[9])) <<< 1;
        n_cl     = 1'b0;
        n_s      = CW'(s_raw);
        if (s_raw > (VW'(1) <<< (CW - 2))) begin
            n_s  = CW'(1) <<< (CW - 2);
            n_cl = 1'b1;
        end else if (s_raw < -(VW'(1) <<< (CW - 2))) begin
            n_s  = -(CW'(1) <<< (CW - 2));
            n_cl = 1'b1;
        end
    end

    // Radicand for the cosine: one squared minus the sine squared.
    always_comb begin
        sq   = r_s * r_s;
        diff = ((2*CW)'(1) <<< (2*CW - 4)) - sq;
        n_n  = NW'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_quat.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p       <= n_p;
            r_yaw_y   <= n_yaw_y;
            r_yaw_x   <= n_yaw_x;
            r_roll_y  <= n_roll_y;
            r_roll_x  <= n_roll_x;
            r_s       <= n_s;
            r_cl      <= n_cl;
            r3_roll_y <= r_roll_y;
            r3_roll_x <= r_roll_x;
            r3_yaw_y  <= r_yaw_y;
            r3_yaw_x  <= r_yaw_x;
            r3_s      <= r_s;
            r3_cl     <= r_cl;
            r3_n      <= n_n;
        end
    end

    assign o_work = {r3_roll_y, r3_roll_x, r3_yaw_y, r3_yaw_x, r3_s, r3_n, r3_cl};

    // A blocked beat in the last stage stays there until the queue takes it.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && i_full |=> r_v3)
        else $error("front dropped a blocked beat");

endmodule
`default_nettype wire

### design/qte_queue.sv
// Short register queue that decouples the front end from the angle pipeline.
`default_nettype none
module qte_queue import qte_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CNTW-1:0]  r_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            r_count <= r_count + CNTW'(i_push) - CNTW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("queue count beyond depth");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + CNTW'(1))
        else $error("queue count did not follow a push");

endmodule
`default_nettype wire

### design/qte_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees times 65536.
`default_nettype none
module qte_cordic import qte_pkg::*; #(
    parameter int VW     = 20,
    parameter int STAGES = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [VW-1:0] i_y,
    input  wire logic signed [VW-1:0] i_x,
    output logic signed [ZW-1:0]      o_z
);
    localparam int XW = VW + 2;

    logic signed [XW-1:0] r_x [STAGES+1];
    logic signed [XW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    logic                 r_zero [STAGES+1];

    logic signed [XW-1:0] xe, ye;

    assign xe = XW'(i_x);
    assign ye = XW'(i_y);

    // Fold the left half plane into the right one before the rotations.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -xe;
                r_y[0] <= -ye;
                r_z[0] <= (i_y >= 0) ? ZW'(DEG180) : -ZW'(DEG180);
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, steered by the sign of y.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [XW-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + atan_deg(i);
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - atan_deg(i);
                end
            end
        end
    end

    assign o_z = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule
`default_nettype wire

### design/qte_back.sv
// Back end: cosine square root, three CORDIC units, rounding and the output register.
`default_nettype none
module qte_back import qte_pkg::*; #(
    parameter int CW = COMPONENT_WIDTH_DEF,
    parameter int AS = ANGLE_STAGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire logic [4*(CW+4)+CW+2*CW-2:0]   i_work,
    output logic                               o_pop,
    qte_euler_if.source                        o_euler
);
    localparam int VW = CW + 4;
    localparam int NW = 2 * CW - 2;
    localparam int K  = CW - 1;
    localparam int RW = K + 3;
    localparam int A  = (AS > ATAN_LEN) ? ATAN_LEN : AS;

    logic en;

    logic                 r_sv [K+1];
    logic [NW-1:0]        r_n  [K+1];
    logic [RW-1:0]        r_rem [K+1];
    logic [K-1:0]         r_root [K+1];
    logic signed [CW-1:0] r_s  [K+1];
    logic                 r_cl [K+1];
    logic signed [VW-1:0] r_ry [K+1];
    logic signed [VW-1:0] r_rx [K+1];
    logic signed [VW-1:0] r_yy [K+1];
    logic signed [VW-1:0] r_yx [K+1];

    logic r_cv [A+1];
    logic r_ccl [A+1];

    logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
    logic signed [ZW-1:0] t_roll, t_pitch, t_yaw;
    logic signed [15:0]   n_roll, n_yaw;
    logic signed [14:0]   n_pitch;

    logic               r_ov, r_ocl;
    logic signed [15:0] r_oroll, r_oyaw;
    logic signed [14:0] r_opitch;

    // The pipeline moves as one whenever the output register can take a beat.
    assign en    = !r_ov || o_euler.ready;
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= o_pop;
        end
    end

    // Unpack a queue beat into the first square-root stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_ry[0], r_rx[0], r_yy[0], r_yx[0], r_s[0], r_n[0], r_cl[0]} <= i_work;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // Digit-by-digit square root, one result bit per stage.
    for (genvar j = 0; j < K; j++) begin : g_sqrt
        logic [RW-1:0] cur, trial;
        assign cur   = {r_rem[j][RW-3:0], r_n[j][NW-1 -: 2]};
        assign trial = RW'({r_root[j], 2'b01});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_n[j+1] <= r_n[j] << 2;
                if (cur >= trial) begin
                    r_rem[j+1]  <= cur - trial;
                    r_root[j+1] <= {r_root[j][K-2:0], 1'b1};
                end else begin
                    r_rem[j+1]  <= cur;
                    r_root[j+1] <= {r_root[j][K-2:0], 1'b0};
                end
                r_s[j+1]  <= r_s[j];
                r_cl[j+1] <= r_cl[j];
                r_ry[j+1] <= r_ry[j];
                r_rx[j+1] <= r_rx[j];
                r_yy[j+1] <= r_yy[j];
                r_yx[j+1] <= r_yx[j];
            end
        end
    end

    qte_cordic #(.VW(VW), .STAGES(A)) u_roll (
        .i_clk (i_clk), .i_en (en), .i_y (r_ry[K]), .i_x (r_rx[K]), .o_z (z_roll)
    );

    qte_cordic #(.VW(VW), .STAGES(A)) u_pitch (
        .i_clk (i_clk), .i_en (en), .i_y (VW'(r_s[K])),
        .i_x   ($signed(VW'(r_root[K]))), .o_z (z_pitch)
    );

    qte_cordic #(.VW(VW), .STAGES(A)) u_yaw (
        .i_clk (i_clk), .i_en (en), .i_y (r_yy[K]), .i_x (r_yx[K]), .o_z (z_yaw)
    );

    // Valid and clamp flag ride alongside the CORDIC stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= A; i++) r_cv[i] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_sv[K];
            for (int i = 0; i < A; i++) r_cv[i+1] <= r_cv[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ccl[0] <= r_cl[K];
            for (int i = 0; i < A; i++) r_ccl[i+1] <= r_ccl[i];
        end
    end

    // Round to degrees times 128 and saturate.
    always_comb begin
        t_roll  = (z_roll  + ZW'(256)) >>> 9;
        t_pitch = (z_pitch + ZW'(256)) >>> 9;
        t_yaw   = (z_yaw   + ZW'(256)) >>> 9;
        if (t_roll > ZW'(ROLL_LIMIT))        n_roll = 16'(ROLL_LIMIT);
        else if (t_roll < -ZW'(ROLL_LIMIT))  n_roll = -16'(ROLL_LIMIT);
        else                                 n_roll = 16'(t_roll);
        if (t_yaw > ZW'(ROLL_LIMIT))         n_yaw = 16'(ROLL_LIMIT);
        else if (t_yaw < -ZW'(ROLL_LIMIT))   n_yaw = -16'(ROLL_LIMIT);
        else                                 n_yaw = 16'(t_yaw);
        if (t_pitch > ZW'(PITCH_LIMIT))       n_pitch = 15'(PITCH_LIMIT);
        else if (t_pitch < -ZW'(PITCH_LIMIT)) n_pitch = -15'(PITCH_LIMIT);
        else                                  n_pitch = 15'(t_pitch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_cv[A];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oroll  <= n_roll;
            r_opitch <= n_pitch;
            r_oyaw   <= n_yaw;
            r_ocl    <= r_ccl[A];
        end
    end

    assign o_euler.valid         = r_ov;
    assign o_euler.roll_deg      = r_oroll;
    assign o_euler.pitch_deg     = r_opitch;
    assign o_euler.yaw_deg       = r_oyaw;
    assign o_euler.pitch_clamped = r_ocl;

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_sv[0])
        else $error("popped beat not captured by the pipeline");

endmodule
`default_nettype wire

### design/quaternion_to_euler_angles.sv
// Throughput: one quaternion per cycle; the multipliers, square-root stages and CORDIC stages
// are all pipelined, and a four-entry queue splits the front end from the angle pipeline.
// The front stalls only when the queue is full; the back stalls only on output backpressure.
// Reset (synchronous, active low) empties the queue and clears every valid bit; no state
// is kept between quaternions.
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int ANGLE_STAGES    = ANGLE_STAGES_DEF,
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);
    localparam int WORKW = 4 * (COMPONENT_WIDTH + 4) + COMPONENT_WIDTH + 2 * COMPONENT_WIDTH - 1;

    logic             push, full, pop, empty;
    logic [WORKW-1:0] work_in, work_out;

    qte_front #(.CW(COMPONENT_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (i_quat),
        .i_full  (full),
        .o_push  (push),
        .o_work  (work_in)
    );

    qte_queue #(.WIDTH(WORKW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (work_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (work_out),
        .o_empty (empty)
    );

    qte_back #(.CW(COMPONENT_WIDTH), .AS(ANGLE_STAGES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_work  (work_out),
        .o_pop   (pop),
        .o_euler (o_euler)
    );

endmodule
`default_nettype wire
